FILE: sv/rta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rta_pkg;

  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  localparam int TEXT_ROWS = 16;
  localparam int ROW_BYTES = 4;
  localparam int NAME_LEN  = 8;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_GROUP     = 2'd0;
  localparam cmd_t CMD_TUNE_CLR  = 2'd1;
  localparam cmd_t CMD_DISP_CLR  = 2'd2;
  localparam cmd_t CMD_READ_CHAR = 2'd3;

  localparam logic [3:0] GROUP_NAME = 4'd0;
  localparam logic [3:0] GROUP_TEXT = 4'd2;
  localparam logic [3:0] SEGS_ALL   = 4'hF;
  localparam logic [7:0] CR_CHAR    = 8'h0D;

  // State of one item between the memory read and the output register.
  typedef struct packed {
    logic       published;
    logic       written;
    logic [3:0] group_type;
    logic       text_read;
    logic [1:0] col;
    logic       cr_mark;
    logic       row_valid;
    logic [7:0] name_char;
  } stage_t;

endpackage

`default_nettype wire

FILE: sv/rds_text_assembler.sv
`timescale 1ns / 1ps
`default_nettype none

// RDS programme-service name and radio-text assembler.
// Input channel s_*: one item per command. s_tuser carries the command
// (group, tune clear, display clear, read character); s_tdata carries
// blocks B, C, D and the read selector and index.
// Output channel m_*: exactly one result item per input item, in order.
// The middle stage registers each accepted item with its synchronous text
// memory read, and the output register then holds the result.
// Throughput: one item per cycle while m_tready is high; the radio text sits in
// a 16 x 32-bit memory written a whole row (or one byte) per item, and the
// carriage-return marks sit in a 64-bit register with a lowest-set-bit clear,
// so each item finishes in a single pass.
// Reset clears the name buffers, the segment mask, the CR marks and the
// per-row valid bits of the text memory; a row never written reads as zero,
// so no clearing pass is needed and items are taken right after reset.
// When m_tready is low the output register holds; the middle stage still
// takes one more item, then s_tready drops until the output drains.
module rds_text_assembler (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // block_b[15:0], block_c[31:16], block_d[47:32], read_buffer[48],
  // read_index[54:49], zero pad [55]
  input  wire logic [rta_pkg::S_TDATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  wire logic [rta_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // name_published[0], text_written[1], group_type[5:2], read_char[13:6],
  // zero pad [15:14]
  output logic [rta_pkg::M_TDATA_W-1:0]       m_tdata
);
  import rta_pkg::*;

  logic [15:0] block_b, block_c, block_d;
  logic        read_buffer;
  logic [5:0]  read_index;
  cmd_t        cmd;

  assign block_b     = s_tdata[15:0];
  assign block_c     = s_tdata[31:16];
  assign block_d     = s_tdata[47:32];
  assign read_buffer = s_tdata[48];
  assign read_index  = s_tdata[54:49];
  assign cmd         = s_tuser;

  logic [31:0] text_mem [TEXT_ROWS];
  logic [31:0] rd_q;
  logic [TEXT_ROWS-1:0] row_valid;

  logic [7:0]  name_build [NAME_LEN];
  logic [7:0]  name_shown [NAME_LEN];
  logic [3:0]  segments_seen;
  logic [63:0] cr_marks;

  stage_t      st1;
  logic        v1;
  logic        vo;
  logic [13:0] out_q;

  logic s_accept, move1;
  assign move1    = v1 && (!vo || m_tready);
  assign s_tready = !v1 || move1;
  assign s_accept = s_tvalid && s_tready;

  // Decode
  logic [3:0] group;
  logic       is_name, is_text, is_tune, is_clr;
  assign group   = block_b[15:12];
  assign is_name = (cmd == CMD_GROUP) && (group == GROUP_NAME);
  assign is_text = (cmd == CMD_GROUP) && (group == GROUP_TEXT) && !block_b[11];
  assign is_tune = (cmd == CMD_TUNE_CLR);
  assign is_clr  = (cmd == CMD_TUNE_CLR) || (cmd == CMD_DISP_CLR);

  // Name assembly
  logic [1:0]  seg;
  logic [3:0]  seen_new;
  logic        publish;
  logic [7:0]  build_new [NAME_LEN];
  assign seg      = block_b[1:0];
  assign seen_new = segments_seen | (4'd1 << seg);
  assign publish  = is_name && (seen_new == SEGS_ALL);

  always_comb begin
    for (int i = 0; i < NAME_LEN; i++) begin
      build_new[i] = name_build[i];
    end
    build_new[{seg, 1'b0}] = block_d[15:8];
    build_new[{seg, 1'b1}] = block_d[7:0];
  end

  // Text row write: char k of a row sits in byte k
  logic [3:0]  row;
  logic [31:0] row_data;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_be;
  logic [3:0]  mem_row;
  logic        mem_we;
  assign row      = block_b[3:0];
  assign row_data = {block_d[7:0], block_d[15:8], block_c[7:0], block_c[15:8]};

  always_comb begin
    mem_we    = s_accept && (is_text || is_clr);
    mem_row   = is_text ? row : 4'd0;
    mem_wdata = is_text ? row_data : 32'd0;
    if (is_text || !row_valid[0]) begin
      mem_be = 4'b1111;
    end else begin
      mem_be = 4'b0001;
    end
  end

  // CR marks: a text group applies its new characters, then drops the lowest mark; a clear drops mark 0
  logic [63:0] cr_upd, cr_lowest, cr_next;
  always_comb begin
    cr_upd = cr_marks;
    if (is_text) begin
      for (int k = 0; k < ROW_BYTES; k++) begin
        cr_upd[{row, 2'(k)}] = (row_data[8*k +: 8] == CR_CHAR);
      end
    end else if (is_clr) begin
      cr_upd[0] = 1'b0;
    end
    cr_lowest = cr_upd & (~cr_upd + 64'd1);
    cr_next   = is_text ? (cr_upd & ~cr_lowest) : cr_upd;
  end

  // A byte that still holds CR but lost its mark reads as zero.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int k = 0; k < ROW_BYTES; k++) begin
        if (mem_be[k]) begin
          text_mem[mem_row][8*k +: 8] <= mem_wdata[8*k +: 8];
        end
      end
    end
    if (s_accept) begin
      rd_q <= text_mem[read_index[5:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      segments_seen <= '0;
      cr_marks      <= '0;
      for (int i = 0; i < NAME_LEN; i++) begin
        name_build[i] <= '0;
        name_shown[i] <= '0;
      end
    end else if (s_accept) begin
      if (mem_we) begin
        row_valid[mem_row] <= 1'b1;
      end
      cr_marks <= cr_next;
      if (is_name) begin
        for (int i = 0; i < NAME_LEN; i++) begin
          name_build[i] <= build_new[i];
          if (publish) begin
            name_shown[i] <= build_new[i];
          end
        end
        segments_seen <= publish ? 4'd0 : seen_new;
      end else if (is_clr) begin
        name_shown[0] <= '0;
        if (is_tune) begin
          name_build[0] <= '0;
        end
      end
    end
  end

  // Middle stage
  stage_t st1_next;
  always_comb begin
    st1_next            = '0;
    st1_next.published  = publish;
    st1_next.written    = is_text;
    st1_next.group_type = (cmd == CMD_GROUP) ? group : 4'd0;
    st1_next.text_read  = (cmd == CMD_READ_CHAR) && read_buffer;
    st1_next.col        = read_index[1:0];
    st1_next.cr_mark    = cr_marks[read_index];
    st1_next.row_valid  = row_valid[read_index[5:2]];
    if ((cmd == CMD_READ_CHAR) && !read_buffer && (read_index < 6'(NAME_LEN))) begin
      st1_next.name_char = name_shown[read_index[2:0]];
    end
  end

  logic [7:0] text_byte, read_char;
  always_comb begin
    text_byte = rd_q[8*st1.col +: 8];
    if (!st1.text_read) begin
      read_char = st1.name_char;
    end else if (!st1.row_valid || (text_byte == CR_CHAR && !st1.cr_mark)) begin
      read_char = 8'd0;
    end else begin
      read_char = text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (s_accept) begin
        v1 <= 1'b1;
      end else if (move1) begin
        v1 <= 1'b0;
      end
      if (move1) begin
        vo <= 1'b1;
      end else if (m_tready) begin
        vo <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      st1 <= st1_next;
    end
    if (move1) begin
      out_q <= {read_char, st1.group_type, st1.written, st1.published};
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = {2'b00, out_q};

  // Checks
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && vo))
    else $error("input stalled with a free stage");

  a_publish_clears: assert property (@(posedge clk) disable iff (rst)
    (s_accept && publish) |=> (segments_seen == 4'd0))
    else $error("segment mask not cleared after publish");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    vo |-> !(out_q[0] && out_q[1]))
    else $error("name published and text written by one item");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (vo && out_q[13:6] != 8'd0) |-> (out_q[5:0] == 6'd0))
    else $error("read result carries group fields");

endmodule

`default_nettype wire
